[sv/blsu_pkg.sv]
package blsu_pkg;

    // func codes
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // access_size codes; the spare code behaves as a word
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    // framebuffer window
    localparam logic [31:0] FB_BASE  = 32'hFFFF_0600;
    localparam int          FB_OFF_W = 16;

    // config port
    localparam int          CFG_ADDR_W   = 3;
    localparam logic        REG_MEM_SPAN = 1'b0;
    localparam logic        REG_FB_EN    = 1'b1;
    localparam int          MEM_SPAN_W   = 17;
    localparam logic [16:0] MEM_SPAN_RST = 17'h1_0000;

    // decoded access, one word lane per bit (bit 3 = lowest address)
    typedef struct packed {
        logic       in_fb;
        logic       oor;
        logic       mis;
        logic [1:0] shift;      // byte shift of the value inside the row
        logic [3:0] size_mask;  // unshifted lane mask of the access size
        logic [3:0] lane_be;    // lanes touched inside the row
    } blsu_dec_t;

endpackage

[sv/big_endian_load_store_unit.sv]
// A word accepted waits in the read stage while its RAM row is read, and its result
// passes into the output register on m_* once that register is free or taken.
// Throughput: one word per cycle after the reset sweep while m_tready is high; the
// main and framebuffer RAMs each take one row access per cycle, and an aligned access
// always fits one row. Reset: synchronous, active low. After reset both RAMs are
// zeroed by a sweep; s_tready stays low until it ends. Config writes are taken
// during the sweep.
module big_endian_load_store_unit import blsu_pkg::*; #(
    parameter int MEM_BYTES = 65536,
    parameter int FB_BYTES  = 64000
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // access words in
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,   // [31:0] address, [63:32] write_data
    input  logic [2:0]            s_tuser,   // [0] func, [2:1] access_size
    // results out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // [31:0] read_data
    output logic [1:0]            m_tuser,   // [0] out_of_range, [1] misaligned
    // config
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int MEM_ROWS = (MEM_BYTES + 3) / 4;
    localparam int FB_ROWS  = (FB_BYTES + 3) / 4;
    localparam int MA_W     = $clog2(MEM_ROWS);
    localparam int FA_W     = $clog2(FB_ROWS);
    localparam int MAX_ROWS = (MEM_ROWS > FB_ROWS) ? MEM_ROWS : FB_ROWS;
    localparam int CLR_W    = $clog2(MAX_ROWS);

    // ---------------- config registers ----------------
    logic [MEM_SPAN_W-1:0] mem_span_reg, mem_span_next;
    logic                  fb_en_reg, fb_en_next;
    logic                  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        mem_span_next = mem_span_reg;
        fb_en_next    = fb_en_reg;
        if (cfg_wr) begin
            unique case (paddr[2])
                REG_MEM_SPAN: mem_span_next = pwdata[MEM_SPAN_W-1:0];
                REG_FB_EN:    fb_en_next    = pwdata[0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MEM_SPAN: prdata = 32'(mem_span_reg);
            REG_FB_EN:    prdata = 32'(fb_en_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_span_reg <= MEM_SPAN_RST;
            fb_en_reg    <= 1'b0;
        end else begin
            mem_span_reg <= mem_span_next;
            fb_en_reg    <= fb_en_next;
        end
    end

    // ---------------- clearing sweep ----------------
    logic             clear_reg, clear_next;
    logic [CLR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             clr_main, clr_fb;

    always_comb begin
        clear_next   = clear_reg;
        clr_cnt_next = clr_cnt_reg;
        if (clear_reg) begin
            clr_cnt_next = clr_cnt_reg + CLR_W'(1);
            if (clr_cnt_reg == CLR_W'(MAX_ROWS - 1)) begin
                clear_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_reg   <= 1'b1;
            clr_cnt_reg <= '0;
        end else begin
            clear_reg   <= clear_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // the smaller RAM finishes early and then sits out the rest of the sweep
    assign clr_main = clear_reg && (32'(clr_cnt_reg) < 32'(MEM_ROWS));
    assign clr_fb   = clear_reg && (32'(clr_cnt_reg) < 32'(FB_ROWS));

    // ---------------- decode ----------------
    logic            in_func;
    logic [1:0]      in_size;
    logic [31:0]     in_addr;
    logic [31:0]     in_wdata;
    blsu_dec_t       dec;
    logic [MA_W-1:0] main_row;
    logic [FA_W-1:0] fb_row;
    logic            accept;
    logic            do_op;
    logic [31:0]     wdata_row;

    assign in_func  = s_tuser[0];
    assign in_size  = s_tuser[2:1];
    assign in_addr  = s_tdata[31:0];
    assign in_wdata = s_tdata[63:32];

    blsu_decode #(
        .MEM_BYTES(MEM_BYTES),
        .FB_BYTES (FB_BYTES)
    ) u_decode (
        .mem_span   (mem_span_reg),
        .fb_enable  (fb_en_reg),
        .access_size(in_size),
        .address    (in_addr),
        .dec        (dec),
        .main_row   (main_row),
        .fb_row     (fb_row)
    );

    assign accept    = s_tvalid && s_tready;
    assign do_op     = accept && !dec.oor && !dec.mis;
    assign wdata_row = in_wdata << {dec.shift, 3'b000};

    // ---------------- RAMs ----------------
    logic            main_en, main_we;
    logic [3:0]      main_be;
    logic [MA_W-1:0] main_addr;
    logic [31:0]     main_wdata, main_rdata;
    logic            fb_en, fb_we;
    logic [3:0]      fb_be;
    logic [FA_W-1:0] fb_addr;
    logic [31:0]     fb_wdata, fb_rdata;

    always_comb begin
        if (clear_reg) begin
            main_en    = clr_main;
            main_we    = 1'b1;
            main_be    = 4'hF;
            main_addr  = clr_cnt_reg[MA_W-1:0];
            main_wdata = '0;
            fb_en      = clr_fb;
            fb_we      = 1'b1;
            fb_be      = 4'hF;
            fb_addr    = clr_cnt_reg[FA_W-1:0];
            fb_wdata   = '0;
        end else begin
            main_en    = do_op && !dec.in_fb;
            main_we    = (in_func == FUNC_WRITE);
            main_be    = dec.lane_be;
            main_addr  = main_row;
            main_wdata = wdata_row;
            fb_en      = do_op && dec.in_fb;
            fb_we      = (in_func == FUNC_WRITE);
            fb_be      = dec.lane_be;
            fb_addr    = fb_row;
            fb_wdata   = wdata_row;
        end
    end

    blsu_ram #(.DEPTH(MEM_ROWS)) u_main_ram (
        .aclk (aclk),
        .en   (main_en),
        .we   (main_we),
        .be   (main_be),
        .addr (main_addr),
        .wdata(main_wdata),
        .rdata(main_rdata)
    );

    blsu_ram #(.DEPTH(FB_ROWS)) u_fb_ram (
        .aclk (aclk),
        .en   (fb_en),
        .we   (fb_we),
        .be   (fb_be),
        .addr (fb_addr),
        .wdata(fb_wdata),
        .rdata(fb_rdata)
    );

    // ---------------- read stage ----------------
    // One word waits here while its RAM row comes back. The RAM output only
    // changes on a new read, which is issued only when this stage drains.
    logic      p1_valid_reg, p1_valid_next;
    logic      p1_rd_reg;
    blsu_dec_t p1_dec_reg;
    logic      p1_move;

    assign p1_move  = p1_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !clear_reg && (!p1_valid_reg || p1_move);

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (accept) begin
            p1_valid_next = 1'b1;
        end else if (p1_move) begin
            p1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_rd_reg  <= do_op && (in_func == FUNC_READ);
            p1_dec_reg <= dec;
        end
    end

    // big-endian extract: shift the value down and keep its size
    logic [31:0] row_sel, row_shr, lane_bits, rd_value;

    assign row_sel   = p1_dec_reg.in_fb ? fb_rdata : main_rdata;
    assign row_shr   = row_sel >> {p1_dec_reg.shift, 3'b000};
    assign lane_bits = {{8{p1_dec_reg.size_mask[3]}}, {8{p1_dec_reg.size_mask[2]}},
                        {8{p1_dec_reg.size_mask[1]}}, {8{p1_dec_reg.size_mask[0]}}};
    assign rd_value  = p1_rd_reg ? (row_shr & lane_bits) : '0;

    // ---------------- output register ----------------
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_data_reg;
    logic        m_oor_reg, m_mis_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (p1_move) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_move) begin
            m_data_reg <= rd_value;
            m_oor_reg  <= p1_dec_reg.oor;
            m_mis_reg  <= p1_dec_reg.mis;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = {m_mis_reg, m_oor_reg};

endmodule

[sv/blsu_ram.sv]
module blsu_ram import blsu_pkg::*; #(
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [3:0]               be,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [31:0]              wdata,
    output logic [31:0]              rdata
);

    logic [31:0] mem_reg [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en && we) begin
            for (int k = 0; k < 4; k++) begin
                if (be[k]) begin
                    mem_reg[addr][8*k +: 8] <= wdata[8*k +: 8];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en && !we) begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/blsu_decode.sv]
module blsu_decode import blsu_pkg::*; #(
    parameter int MEM_BYTES = 65536,
    parameter int FB_BYTES  = 64000
) (
    input  logic [MEM_SPAN_W-1:0]                  mem_span,
    input  logic                                   fb_enable,
    input  logic [1:0]                             access_size,
    input  logic [31:0]                            address,
    output blsu_dec_t                              dec,
    output logic [$clog2((MEM_BYTES+3)/4)-1:0]     main_row,
    output logic [$clog2((FB_BYTES+3)/4)-1:0]      fb_row
);

    localparam int MA_W = $clog2((MEM_BYTES + 3) / 4);
    localparam int FA_W = $clog2((FB_BYTES + 3) / 4);

    logic [2:0]          nbytes;
    logic [3:0]          size_mask;
    logic                mis;
    logic                in_fb;
    logic [32:0]         main_lim;
    logic [32:0]         main_end;
    logic [FB_OFF_W-1:0] fb_off;
    logic [16:0]         fb_end;
    logic [2:0]          shift_w;

    always_comb begin
        case (access_size)
            SIZE_BYTE: begin
                nbytes    = 3'd1;
                size_mask = 4'b0001;
                mis       = 1'b0;
            end
            SIZE_HALF: begin
                nbytes    = 3'd2;
                size_mask = 4'b0011;
                mis       = address[0];
            end
            default: begin
                nbytes    = 3'd4;
                size_mask = 4'b1111;
                mis       = |address[1:0];
            end
        endcase
    end

    assign in_fb    = (address >= FB_BASE);
    assign main_lim = (33'(mem_span) > 33'(MEM_BYTES)) ? 33'(MEM_BYTES) : 33'(mem_span);
    assign main_end = {1'b0, address} + 33'(nbytes);
    assign fb_off   = address[FB_OFF_W-1:0] - FB_BASE[FB_OFF_W-1:0];
    assign fb_end   = 17'(fb_off) + 17'(nbytes);

    // big-endian: lowest address in the top lane
    assign shift_w  = 3'd4 - nbytes - {1'b0, address[1:0]};

    always_comb begin
        dec.in_fb     = in_fb;
        dec.mis       = mis;
        dec.oor       = in_fb ? (!fb_enable || (fb_end > 17'(FB_BYTES)))
                              : (main_end > main_lim);
        dec.shift     = shift_w[1:0];
        dec.size_mask = size_mask;
        dec.lane_be   = 4'(size_mask << shift_w[1:0]);
    end

    assign main_row = address[MA_W+1:2];
    assign fb_row   = fb_off[FA_W+1:2];

endmodule

[sv/blsu_check.sv]
module blsu_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        pready
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a faulty access reads zero
    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != 2'b00) |-> m_tdata == 32'd0)
        else $error("faulty access returned data");

    // the clearing sweep blocks input right after reset
    a_clear_block: assert property (@(posedge aclk)
        $rose(aresetn) |-> !s_tready)
        else $error("input taken during RAM clear");

    // no result appears without an earlier accepted word
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without an accepted word");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

endmodule

bind big_endian_load_store_unit blsu_check u_blsu_check (.*);

[tb/tb_big_endian_load_store_unit.sv]
`timescale 1ns / 100ps

module tb_big_endian_load_store_unit;
    import blsu_pkg::*;

    localparam int          MAIN_BYTES  = 65536;
    localparam int          FRAME_BYTES = 64000;
    // spare size code, decoded as a word by the block
    localparam logic [1:0]  SIZE_SPARE  = 2'd3;
    // cycles without any handshake before the run is called hung; covers the
    // post-reset RAM sweep several times over
    localparam int          HANG_LIMIT  = 60000;
    // drain time after the last result (pipeline is two deep)
    localparam int          TAIL_CYCLES = 20;
    localparam int          NUM_PHASES  = 7;
    localparam int          RAND_PER_PHASE = 79;

    typedef struct packed {
        logic        func;
        logic [1:0]  size;
        logic [31:0] addr;
        logic [31:0] wdata;
    } mem_access_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        out_of_range;
        logic        misaligned;
    } access_result_t;

    // ------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [63:0]           s_tdata  = '0;  // [31:0] address, [63:32] write_data
    logic [2:0]            s_tuser  = '0;  // [0] func, [2:1] access_size
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;        // [31:0] read_data
    logic [1:0]            m_tuser;        // [0] out_of_range, [1] misaligned
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;

    big_endian_load_store_unit #(
        .MEM_BYTES (MAIN_BYTES),
        .FB_BYTES  (FRAME_BYTES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Shadow of the block: both byte stores and the two registers
    // ------------------------------------------------------------------
    logic [7:0]  main_bytes  [MAIN_BYTES];
    logic [7:0]  frame_bytes [FRAME_BYTES];
    logic [16:0] mem_span_cfg;
    logic        fb_enable_cfg;

    mem_access_t    pending_accesses[$];   // words waiting for the driver
    access_result_t expected_results[$];   // one per accepted word, in order

    logic        s_fire = 1'b0;            // input word taken at the last edge
    int          burst_left = 1;
    int          gap_left   = 0;
    int          ready_mode = 0;
    int          ready_hold = 0;
    int          hang_cycles = 0;
    int unsigned words_accepted = 0;
    int unsigned results_checked = 0;
    int unsigned range_faults = 0;
    int unsigned align_faults = 0;
    int unsigned mismatch_count = 0;

    function automatic int unsigned access_bytes(logic [1:0] size);
        return (size == SIZE_BYTE) ? 1 : (size == SIZE_HALF) ? 2 : 4;
    endfunction

    function automatic int unsigned usable_main();
        return (mem_span_cfg > MAIN_BYTES) ? MAIN_BYTES : mem_span_cfg;
    endfunction

    // Applies one access to the shadow stores and returns what the block owes.
    function automatic access_result_t predict_access(mem_access_t a);
        access_result_t    r;
        int unsigned       nb;
        int unsigned       sh;
        longint unsigned   off;
        logic              to_fb;
        logic [7:0]        b;
        r     = '0;
        nb    = access_bytes(a.size);
        to_fb = (a.addr >= FB_BASE);
        r.misaligned = (a.addr & (nb - 1)) != 0;
        if (!to_fb) begin
            off = a.addr;
            r.out_of_range = (off + nb) > usable_main();
        end else begin
            off = a.addr - FB_BASE;
            r.out_of_range = !fb_enable_cfg || (off + nb) > FRAME_BYTES;
        end
        // faulty accesses neither store nor load
        if (!r.out_of_range && !r.misaligned) begin
            for (int i = 0; i < nb; i++) begin
                sh = 8 * (nb - 1 - i);   // lowest address carries the MSB
                if (a.func == FUNC_WRITE) begin
                    b = a.wdata >> sh;
                    if (to_fb)
                        frame_bytes[off + i] = b;
                    else
                        main_bytes[off + i] = b;
                end else begin
                    b = to_fb ? frame_bytes[off + i] : main_bytes[off + i];
                    r.read_data = r.read_data | ({24'b0, b} << sh);
                end
            end
        end
        return r;
    endfunction

    // Address mix: dense low memory so reads hit earlier writes, the edge of
    // the usable main region, both ends of the framebuffer, the seam at the
    // framebuffer base, random main-memory addresses and fully random addresses.
    function automatic mem_access_t random_access();
        mem_access_t a;
        int unsigned kind;
        int unsigned lim;
        int unsigned size_pick;
        kind = $urandom_range(0, 99);
        lim  = usable_main();
        if (kind < 35)
            a.addr = $urandom_range(0, 255);
        else if (kind < 50)
            a.addr = ((lim > 8) ? lim - 8 : 0) + $urandom_range(0, 12);
        else if (kind < 65)
            a.addr = FB_BASE + $urandom_range(0, 255);
        else if (kind < 75)
            a.addr = 32'hFFFF_FFF0 + $urandom_range(0, 15);
        else if (kind < 82)
            a.addr = FB_BASE - 8 + $urandom_range(0, 15);
        else if (kind < 90)
            a.addr = $urandom_range(0, 65535);
        else
            a.addr = $urandom;
        size_pick = $urandom_range(0, 9);
        a.size = (size_pick < 3) ? SIZE_BYTE : (size_pick < 6) ? SIZE_HALF :
                 (size_pick < 9) ? SIZE_WORD : SIZE_SPARE;
        // mostly aligned so that most accesses actually reach the stores
        if ($urandom_range(0, 9) < 8)
            a.addr = a.addr & ~(access_bytes(a.size) - 1);
        a.func  = $urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ;
        a.wdata = $urandom;
        return a;
    endfunction

    task automatic add_access(logic func, logic [1:0] size, logic [31:0] addr,
                              logic [31:0] wdata);
        mem_access_t a;
        a.func  = func;
        a.size  = size;
        a.addr  = addr;
        a.wdata = wdata;
        pending_accesses.push_back(a);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic cfg_write(logic idx, logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == REG_MEM_SPAN)
            mem_span_cfg = value[16:0];
        else
            fb_enable_cfg = value[0];
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Every word yields a result, so an empty expectation queue means the
    // pipeline is empty and a register write is safe.
    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_accesses.size() != 0 || s_tvalid || expected_results.size() != 0);
    endtask

    task automatic set_config(logic [16:0] span, logic fb_en);
        wait_idle();
        cfg_write(REG_MEM_SPAN, {15'b0, span});
        cfg_write(REG_FB_EN, {31'b0, fb_en});
    endtask

    // ------------------------------------------------------------------
    // Input driver: bursts of words with random gaps, changes on falling edge
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        mem_access_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_fire) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_accesses.size() > 0) begin
                nxt = pending_accesses.pop_front();
                s_tdata  <= {nxt.wdata, nxt.addr};
                s_tuser  <= {nxt.size, nxt.func};
                s_tvalid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left = burst_left - 1;
                end else begin
                    // a third of the bursts run straight into the next one
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: stall modes held for random stretches
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
        end else begin
            ready_mode = $urandom_range(0, 3);
            ready_hold = $urandom_range(8, 60);
        end
        case (ready_mode)
            0: m_tready <= 1'b1;                          // no back-pressure
            1: m_tready <= $urandom_range(0, 1);
            2: m_tready <= ($urandom_range(0, 3) == 0);   // heavy stall
            default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Monitor and scoreboard, sampled on the rising edge
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        mem_access_t    a;
        access_result_t got;
        access_result_t want;
        s_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.read_data    = m_tdata;
                got.out_of_range = m_tuser[0];
                got.misaligned   = m_tuser[1];
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result word with nothing expected: data %h flags %b",
                                 $realtime, m_tdata, m_tuser);
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (got.read_data !== want.read_data ||
                        got.out_of_range !== want.out_of_range ||
                        got.misaligned !== want.misaligned) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: result %0d: exp data %h oor %b mis %b, got data %h oor %b mis %b",
                                     $realtime, results_checked, want.read_data,
                                     want.out_of_range, want.misaligned, got.read_data,
                                     got.out_of_range, got.misaligned);
                    end
                end
            end
            // this word's result still has to pass the read stage, so it cannot be the one above
            if (s_tvalid && s_tready) begin
                a.func  = s_tuser[0];
                a.size  = s_tuser[2:1];
                a.addr  = s_tdata[31:0];
                a.wdata = s_tdata[63:32];
                want = predict_access(a);
                expected_results.push_back(want);
                words_accepted++;
                if (want.out_of_range) range_faults++;
                if (want.misaligned) align_faults++;
            end
        end
        // watchdog: any handshake on any port counts as progress
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pready)) begin
            hang_cycles = 0;
        end else begin
            hang_cycles = hang_cycles + 1;
            if (hang_cycles >= HANG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                         $realtime, HANG_LIMIT, expected_results.size());
                $display("FAIL big_endian_load_store_unit");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    logic [16:0] phase_mem_span [NUM_PHASES] =
        '{17'd65536, 17'h1_FFFF, 17'd1000, 17'd0, 17'd3, 17'd65535, 17'd4096};
    logic        phase_fb_en    [NUM_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

    initial begin
        foreach (main_bytes[i]) main_bytes[i] = 8'h00;
        foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
        mem_span_cfg  = MEM_SPAN_RST;
        fb_enable_cfg = 1'b0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: full main memory, framebuffer on
        set_config(17'd65536, 1'b1);
        add_access(FUNC_WRITE, SIZE_WORD, 32'h0000_0000, 32'h1122_3344);
        add_access(FUNC_READ,  SIZE_WORD, 32'h0000_0000, 32'h0);
        add_access(FUNC_READ,  SIZE_BYTE, 32'h0000_0001, 32'h0);      // byte order
        add_access(FUNC_READ,  SIZE_HALF, 32'h0000_0002, 32'h0);
        add_access(FUNC_WRITE, SIZE_BYTE, 32'h0000_0003, 32'hFFFF_FFAA); // only low byte kept
        add_access(FUNC_READ,  SIZE_WORD, 32'h0000_0000, 32'h0);
        add_access(FUNC_WRITE, SIZE_HALF, 32'h0000_FFFE, 32'h0000_BEEF); // last half of memory
        add_access(FUNC_READ,  SIZE_WORD, 32'h0000_FFFC, 32'h0);
        add_access(FUNC_READ,  SIZE_WORD, 32'h0000_FFFE, 32'h0);      // misaligned and past end
        add_access(FUNC_READ,  SIZE_HALF, 32'h0000_FFFF, 32'h0);      // misaligned and past end
        add_access(FUNC_WRITE, SIZE_WORD, 32'h0001_0000, 32'hFFFF_FFFF); // just past memory
        add_access(FUNC_READ,  SIZE_BYTE, FB_BASE - 1,   32'h0);      // top of main side
        add_access(FUNC_WRITE, SIZE_WORD, FB_BASE,       32'hCAFE_F00D);
        add_access(FUNC_READ,  SIZE_WORD, FB_BASE,       32'h0);
        add_access(FUNC_WRITE, SIZE_BYTE, 32'hFFFF_FFFF, 32'h0000_005A); // last framebuffer byte
        add_access(FUNC_READ,  SIZE_WORD, 32'hFFFF_FFFC, 32'h0);
        add_access(FUNC_READ,  SIZE_WORD, 32'hFFFF_FFFE, 32'h0);      // both faults
        add_access(FUNC_WRITE, SIZE_SPARE, 32'h0000_0008, 32'hDEAD_BEEF); // spare size = word
        add_access(FUNC_READ,  SIZE_SPARE, 32'h0000_0008, 32'h0);
        add_access(FUNC_READ,  SIZE_SPARE, 32'h0000_000A, 32'h0);
        add_access(FUNC_WRITE, SIZE_WORD, 32'h0000_0006, 32'hFFFF_FFFF); // misaligned, no store
        add_access(FUNC_READ,  SIZE_WORD, 32'h0000_0004, 32'h0);
        add_access(FUNC_WRITE, SIZE_HALF, 32'h0000_0000, 32'h0000_0000);

        // one usable byte, framebuffer off: partial fit and disabled window
        set_config(17'd1, 1'b0);
        add_access(FUNC_READ,  SIZE_BYTE, 32'h0000_0000, 32'h0);
        add_access(FUNC_READ,  SIZE_HALF, 32'h0000_0000, 32'h0);
        add_access(FUNC_WRITE, SIZE_BYTE, 32'h0000_0001, 32'h0000_0077);
        add_access(FUNC_READ,  SIZE_BYTE, FB_BASE,       32'h0);

        // random phases over a spread of register settings, extremes included
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_config(phase_mem_span[p], phase_fb_en[p]);
            for (int n = 0; n < RAND_PER_PHASE; n++)
                pending_accesses.push_back(random_access());
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0) begin
            mismatch_count += expected_results.size();
            $display("%0d expected results never arrived", expected_results.size());
        end

        $display("Ran %0d access words over %0d register settings; %0d results checked.",
                 words_accepted, NUM_PHASES + 2, results_checked);
        $display("Faults seen: %0d out of range, %0d misaligned; %0d mismatches.",
                 range_faults, align_faults, mismatch_count);
        if (mismatch_count == 0)
            $display("PASS big_endian_load_store_unit");
        else
            $display("FAIL big_endian_load_store_unit");
        $finish;
    end

endmodule
